@@ hdl/mpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants of the Mandelbrot pixel colour block
// Number formats, controller commands and status, and the shaping table.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

   localparam int MAX_ITERATIONS = 100;
   localparam int FRACTION_BITS  = 28;

   localparam int COORD_W  = 12;
   localparam int DIM_W    = 13;
   localparam int COLOUR_W = 24;
   localparam int CHAN_W   = 8;
   localparam int SHAPE_W  = 16;

   localparam int NUM_W     = COORD_W + 2;
   localparam int QUOT_W    = NUM_W + FRACTION_BITS;
   localparam int DIV_STEPS = QUOT_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   // Signed point and z values with a range of plus or minus sixteen.
   localparam int Z_W    = FRACTION_BITS + 5;
   localparam int PROD_W = 2 * Z_W;
   localparam int SQ_W   = PROD_W - FRACTION_BITS;
   localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

   localparam int OFFSET_W = 2;
   localparam logic [OFFSET_W-1:0] OFFSET_X = 2'd2;
   localparam logic [OFFSET_W-1:0] OFFSET_Y = 2'd1;

   localparam logic [Z_W-1:0] FOUR_FX = Z_W'(4) << FRACTION_BITS;
   localparam logic signed [SQ_W:0] ESCAPE_LIMIT = (SQ_W + 1)'(4) << FRACTION_BITS;

   localparam int BLEND_W = CHAN_W + SHAPE_W + 1;
   localparam logic [SHAPE_W:0] SHAPE_ONE = (SHAPE_W + 1)'(1) << SHAPE_W;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSIDE_COLOUR  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTSIDE_COLOUR = 2'd3;

   localparam logic [DIM_W-1:0]    RESET_IMAGE_WIDTH    = 13'd200;
   localparam logic [DIM_W-1:0]    RESET_IMAGE_HEIGHT   = 13'd200;
   localparam logic [COLOUR_W-1:0] RESET_INSIDE_COLOUR  = 24'hFF00FF;
   localparam logic [COLOUR_W-1:0] RESET_OUTSIDE_COLOUR = 24'h00FF00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_SEED,
      ST_MUL,
      ST_UPDATE,
      ST_SHAPE,
      ST_BLEND
   } state_type;

   typedef struct packed {
      logic load;
      logic map_step;
      logic seed;
      logic mul;
      logic update;
      logic shape;
      logic blend;
   } cmd_type;

   typedef struct packed {
      logic map_done;
      logic escaped;
      logic iter_last;
   } status_type;

   // Entry i is the largest s with s^5 * MAX_ITERATIONS <= i * 2^(5*SHAPE_W).
   function automatic logic [SHAPE_W*MAX_ITERATIONS-1:0] build_shape_table();
      logic [SHAPE_W*MAX_ITERATIONS-1:0] tbl;
      logic [SHAPE_W-1:0] s;
      logic [SHAPE_W-1:0] cand;
      logic [95:0] pw;
      logic [95:0] lim;
      tbl = '0;
      for (int i = 0; i < MAX_ITERATIONS; i++) begin
         s   = '0;
         lim = 96'(i) << (5 * SHAPE_W);
         for (int b = SHAPE_W - 1; b >= 0; b--) begin
            cand = s | (SHAPE_W'(1) << b);
            pw   = 96'(cand);
            pw   = pw * 96'(cand);
            pw   = pw * 96'(cand);
            pw   = pw * 96'(cand);
            pw   = pw * 96'(cand);
            pw   = pw * 96'(MAX_ITERATIONS);
            if (pw <= lim) begin
               s = cand;
            end
         end
         tbl[i*SHAPE_W +: SHAPE_W] = s;
      end
      return tbl;
   endfunction

   localparam logic [SHAPE_W*MAX_ITERATIONS-1:0] SHAPE_TABLE = build_shape_table();

endpackage

`default_nettype wire

@@ hdl/mandelbrot_pixel_colour.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_pixel_colour: escape-time colour of one Mandelbrot pixel
// Each request carries a pixel coordinate; each result carries its colour.
// Request tdata packs pixel_x and pixel_y; result tdata packs red, green and
// blue. Image size and the two blend colours are set through the csr port
// while the block is idle: a rule for the user that the block does not enforce.
// One request is worked on at a time. Mapping runs in a bit-serial divider,
// then the shared complex multiply unit works each iteration in a multiply
// step and an update step. The next request is accepted once the result sits
// in the output register, so a stalled receiver holds only the last result;
// a further result waits in the blend step until the output register is free.
// Reset is synchronous: it returns the sequencer to idle, drops the result
// valid and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_pixel_colour
   import mpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [23:0]            req_tdata,  // pixel_x [11:0], pixel_y [23:12]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [23:0]                 rsp_tdata,  // red [7:0], green [15:8], blue [23:16]
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COLOUR_W-1:0]    csr_wdata
);

   logic [DIM_W-1:0]    width_ff, height_ff;
   logic [COLOUR_W-1:0] inside_ff, outside_ff;
   cmd_type             cmd;
   status_type          status;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RESET_IMAGE_WIDTH;
         height_ff  <= RESET_IMAGE_HEIGHT;
         inside_ff  <= RESET_INSIDE_COLOUR;
         outside_ff <= RESET_OUTSIDE_COLOUR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:    width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:   height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_INSIDE_COLOUR:  inside_ff  <= csr_wdata;
            CSR_OUTSIDE_COLOUR: outside_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mpc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mpc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .pixel_x        (req_tdata[COORD_W-1:0]),
      .pixel_y        (req_tdata[2*COORD_W-1:COORD_W]),
      .image_width    (width_ff),
      .image_height   (height_ff),
      .inside_colour  (inside_ff),
      .outside_colour (outside_ff),
      .colour         (rsp_tdata)
   );

   a_busy_after_request : assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready
   ) else $error("Block accepted a request while still working on one.");

   a_result_follows_work : assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready)
   ) else $error("A result appeared without a request being worked on.");

endmodule

`default_nettype wire

@@ hdl/mpc_map.sv @@
// ----------------------------------------------------------------------------
// mpc_map: pixel coordinate to fixed-point point component
// Restoring divider that forms floor(3v * 2^F / d) one bit per step, then
// removes the offset and saturates large values at four.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_map
   import mpc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire logic                       step,
   input  wire logic [COORD_W-1:0]         coord,
   input  wire logic [DIM_W-1:0]           dim,
   input  wire logic [OFFSET_W-1:0]        offset,
   output logic signed [Z_W-1:0]           c
);

   logic [QUOT_W-1:0] num_ff, num_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [DIM_W-1:0]  den_ff, den_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  num3;
   logic [DIM_W:0]    trial;
   logic [DIM_W:0]    diff;
   logic [NUM_W-1:0]  qint;
   logic [NUM_W-1:0]  qlimit;

   always_comb begin
      num3    = NUM_W'({coord, 1'b0}) + NUM_W'(coord);
      trial   = {rem_ff, num_ff[QUOT_W-1]};
      diff    = trial - {1'b0, den_ff};
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (load) begin
         num_in  = {num3, {FRACTION_BITS{1'b0}}};
         quot_in = '0;
         rem_in  = '0;
         den_in  = (dim == '0) ? DIM_W'(1) : dim;
      end else if (step) begin
         num_in = {num_ff[QUOT_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = diff[DIM_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIM_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
   end

   always_comb begin
      qint   = quot_ff[QUOT_W-1:FRACTION_BITS];
      qlimit = NUM_W'(4) + NUM_W'(offset);
      if (qint >= qlimit) begin
         c = FOUR_FX;
      end else begin
         c = quot_ff[Z_W-1:0] - (Z_W'(offset) << FRACTION_BITS);
      end
   end

endmodule

`default_nettype wire

@@ hdl/mpc_datapath.sv @@
// ----------------------------------------------------------------------------
// mpc_datapath: mapping, escape iteration, shaping and colour blend
// Holds the point, z, the product registers of the complex multiply unit,
// the step and iteration counters and the output colour register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_datapath
   import mpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [COORD_W-1:0]    pixel_x,
   input  wire logic [COORD_W-1:0]    pixel_y,
   input  wire logic [DIM_W-1:0]      image_width,
   input  wire logic [DIM_W-1:0]      image_height,
   input  wire logic [COLOUR_W-1:0]   inside_colour,
   input  wire logic [COLOUR_W-1:0]   outside_colour,
   output logic [COLOUR_W-1:0]        colour
);

   logic signed [Z_W-1:0]    cx_map, cy_map;
   logic signed [Z_W-1:0]    cx_ff, cy_ff, zx_ff, zy_ff;
   logic signed [PROD_W-1:0] pxx_ff, pyy_ff, pxy_ff;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic [ITER_W-1:0]        esc_ff;
   logic [SHAPE_W-1:0]       shape_ff;
   logic [COLOUR_W-1:0]      colour_ff, colour_in;

   logic signed [SQ_W-1:0]   sqx, sqy, sxy;
   logic signed [SQ_W:0]     mag;
   logic signed [SQ_W-1:0]   nx_wide, ny_wide;
   logic                     escaped;
   logic [SHAPE_W:0]         inv_shape;
   logic [BLEND_W-1:0]       blend;

   mpc_map u_map_x (
      .clock  (clock),
      .load   (cmd.load),
      .step   (cmd.map_step),
      .coord  (pixel_x),
      .dim    (image_width),
      .offset (OFFSET_X),
      .c      (cx_map)
   );

   mpc_map u_map_y (
      .clock  (clock),
      .load   (cmd.load),
      .step   (cmd.map_step),
      .coord  (pixel_y),
      .dim    (image_height),
      .offset (OFFSET_Y),
      .c      (cy_map)
   );

   always_comb begin
      sqx     = pxx_ff[FRACTION_BITS +: SQ_W];
      sqy     = pyy_ff[FRACTION_BITS +: SQ_W];
      sxy     = pxy_ff[FRACTION_BITS +: SQ_W];
      mag     = (SQ_W + 1)'(sqx) + (SQ_W + 1)'(sqy);
      escaped = (iter_ff != '0) && (mag > ESCAPE_LIMIT);
      nx_wide = sqx - sqy + SQ_W'(cx_ff);
      ny_wide = (sxy <<< 1) + SQ_W'(cy_ff);
   end

   assign status.map_done  = (step_ff == STEP_W'(DIV_STEPS));
   assign status.escaped   = escaped;
   assign status.iter_last = (iter_ff == ITER_W'(MAX_ITERATIONS));

   always_comb begin
      step_in = step_ff;
      iter_in = iter_ff;
      if (cmd.load) begin
         step_in = '0;
      end else if (cmd.map_step) begin
         step_in = step_ff + STEP_W'(1);
      end
      if (cmd.seed) begin
         iter_in = '0;
      end else if (cmd.update && !status.iter_last) begin
         iter_in = iter_ff + ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         iter_ff <= '0;
      end else begin
         step_ff <= step_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seed) begin
         cx_ff <= cx_map;
         cy_ff <= cy_map;
         zx_ff <= '0;
         zy_ff <= '0;
      end else if (cmd.update) begin
         zx_ff  <= nx_wide[Z_W-1:0];
         zy_ff  <= ny_wide[Z_W-1:0];
         esc_ff <= escaped ? (iter_ff - ITER_W'(1)) : '0;
      end
      if (cmd.mul) begin
         pxx_ff <= PROD_W'(zx_ff) * PROD_W'(zx_ff);
         pyy_ff <= PROD_W'(zy_ff) * PROD_W'(zy_ff);
         pxy_ff <= PROD_W'(zx_ff) * PROD_W'(zy_ff);
      end
      if (cmd.shape) begin
         shape_ff <= SHAPE_TABLE[esc_ff*SHAPE_W +: SHAPE_W];
      end
      colour_ff <= colour_in;
   end

   // Output word holds red in the lowest byte; the colour registers hold it highest.
   always_comb begin
      inv_shape = SHAPE_ONE - (SHAPE_W + 1)'(shape_ff);
      colour_in = colour_ff;
      blend     = '0;
      if (cmd.blend) begin
         for (int k = 0; k < 3; k++) begin
            blend = BLEND_W'(inside_colour[(2-k)*CHAN_W +: CHAN_W]) * BLEND_W'(shape_ff)
                  + BLEND_W'(outside_colour[(2-k)*CHAN_W +: CHAN_W]) * BLEND_W'(inv_shape);
            colour_in[k*CHAN_W +: CHAN_W] = blend[SHAPE_W +: CHAN_W];
         end
      end
   end

   assign colour = colour_ff;

endmodule

`default_nettype wire

@@ hdl/mpc_controller.sv @@
// ----------------------------------------------------------------------------
// mpc_controller: sequencer of the Mandelbrot pixel colour block
// Steps the datapath through mapping, iteration, shaping and blending, and
// owns the request and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_controller
   import mpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (status.map_done) begin
               state_in = ST_SEED;
            end else begin
               cmd.map_step = 1'b1;
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.escaped || status.iter_last) begin
               state_in = ST_SHAPE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SHAPE: begin
            cmd.shape = 1'b1;
            state_in  = ST_BLEND;
         end
         ST_BLEND: begin
            if (!valid_ff || rsp_tready) begin
               cmd.blend = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      valid_in = cmd.blend | (valid_ff & ~rsp_tready);
   end

   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

@@ tb/tb_mandelbrot_pixel_colour.sv @@
// ----------------------------------------------------------------------------
// tb_mandelbrot_pixel_colour: self-checking bench for the pixel colour block
// A short table of pixel requests and register writes covers the corners,
// then each phase sets image size and colours and sends random pixels, with
// sender and receiver idling in turn. Every result is checked against a table
// colour or an in-bench fixed-point escape-time predictor, one per request.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mandelbrot_pixel_colour
   import mpc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int PHASES        = 12;
   localparam int PIXELS_PER_PH = 60;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 300;
   localparam int BUSY_PCT      = 71;
   localparam int LIGHT_PCT     = 6;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } colour_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      colour_type         colour;
   } pending_colour_type;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;
   typedef enum logic {FROM_PREDICTOR, FROM_TABLE} colour_src_type;
   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [COLOUR_W-1:0]    wdata;
      logic [COORD_W-1:0]     x;
      logic [COORD_W-1:0]     y;
      colour_src_type         src;
      logic [23:0]            rgb;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd0,    12'd0,    FROM_TABLE,     24'h00FF00},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd4095, 12'd4095, FROM_TABLE,     24'h00FF00},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd4095, 12'd0,    FROM_TABLE,     24'h00FF00},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd0,    12'd4095, FROM_TABLE,     24'h00FF00},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'hAAA,  12'h555,  FROM_TABLE,     24'h00FF00},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'h555,  12'hAAA,  FROM_TABLE,     24'h00FF00},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd100,  12'd100,  FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd100,  12'd67,   FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd133,  12'd67,   FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd30,   12'd70,   FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd50,   12'd120,  FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd199,  12'd199,  FROM_PREDICTOR, 24'h0},
      '{ROW_WRITE, CSR_IMAGE_WIDTH,    24'h0,      12'd0,    12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_WRITE, CSR_IMAGE_HEIGHT,   24'h0,      12'd0,    12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd0,    12'd0,    FROM_TABLE,     24'h00FF00},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd1,    12'd1,    FROM_TABLE,     24'h00FF00},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd1,    12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_WRITE, CSR_INSIDE_COLOUR,  24'h000000, 12'd0,    12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_WRITE, CSR_OUTSIDE_COLOUR, 24'hFFFFFF, 12'd0,    12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd0,    12'd0,    FROM_TABLE,     24'hFFFFFF},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd1,    12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_WRITE, CSR_IMAGE_WIDTH,    24'hFFF000, 12'd0,    12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_WRITE, CSR_IMAGE_HEIGHT,   24'h001FFF, 12'd0,    12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd4095, 12'd4095, FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd2730, 12'd0,    FROM_PREDICTOR, 24'h0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,    24'h0,      12'd2048, 12'd4095, FROM_PREDICTOR, 24'h0}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_IMAGE_WIDTH;
   logic [COLOUR_W-1:0]    csr_wdata  = '0;

   logic [DIM_W-1:0]    cfg_width   = RESET_IMAGE_WIDTH;
   logic [DIM_W-1:0]    cfg_height  = RESET_IMAGE_HEIGHT;
   logic [COLOUR_W-1:0] cfg_inside  = RESET_INSIDE_COLOUR;
   logic [COLOUR_W-1:0] cfg_outside = RESET_OUTSIDE_COLOUR;

   int unsigned        shape_lut [MAX_ITERATIONS];
   pending_colour_type colours_due [$];
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 fault_count    = 0;
   int                 colours_checked = 0;
   int                 pixels_sent    = 0;
   longint             cycle_count    = 0;

   mandelbrot_pixel_colour DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pixel_x [11:0], pixel_y [23:12]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // red [7:0], green [15:8], blue [23:16]
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint fx_product(longint a, longint b);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] p;
      wa = a;
      wb = b;
      p  = (wa * wb) >>> FRACTION_BITS;
      return p[63:0];
   endfunction

   function automatic longint map_axis(logic [COORD_W-1:0] v, logic [DIM_W-1:0] d,
                                       longint offset);
      longint num;
      longint den;
      longint q;
      longint r;
      den = (d == 0) ? 1 : longint'(d);
      num = 3 * longint'(v);
      q   = num / den;
      r   = num % den;
      if (q >= 4 + offset) begin
         return longint'(4) << FRACTION_BITS;
      end
      return (q << FRACTION_BITS) + ((r << FRACTION_BITS) / den) - (offset << FRACTION_BITS);
   endfunction

   function automatic int escape_step(longint cx, longint cy);
      longint zx;
      longint zy;
      longint nx;
      longint ny;
      zx = 0;
      zy = 0;
      for (int i = 0; i < MAX_ITERATIONS; i++) begin
         nx = fx_product(zx, zx) - fx_product(zy, zy) + cx;
         ny = 2 * fx_product(zx, zy) + cy;
         zx = nx;
         zy = ny;
         if (fx_product(zx, zx) + fx_product(zy, zy) > (longint'(4) << FRACTION_BITS)) begin
            return i;
         end
      end
      return 0;
   endfunction

   function automatic bit fifth_power_fits(int unsigned s, int unsigned i);
      logic [127:0] p;
      logic [127:0] bound;
      p = 128'(s);
      repeat (4) p = p * 128'(s);
      p     = p * 128'(MAX_ITERATIONS);
      bound = 128'(i) << (5 * SHAPE_W);
      return p <= bound;
   endfunction

   function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] a,
                                                     logic [CHAN_W-1:0] b,
                                                     int unsigned s);
      longint v;
      v = longint'(a) * s + longint'(b) * (65536 - s);
      return CHAN_W'(v >> SHAPE_W);
   endfunction

   function automatic colour_type predict_colour(logic [COORD_W-1:0] x,
                                                 logic [COORD_W-1:0] y);
      colour_type  c;
      int unsigned s;
      s       = shape_lut[escape_step(map_axis(x, cfg_width, 2), map_axis(y, cfg_height, 1))];
      c.red   = mix_channel(cfg_inside[23:16], cfg_outside[23:16], s);
      c.green = mix_channel(cfg_inside[15:8],  cfg_outside[15:8],  s);
      c.blue  = mix_channel(cfg_inside[7:0],   cfg_outside[7:0],   s);
      return c;
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(logic [DIM_W-1:0] dim);
      int span;
      span = (dim == 0) ? 1 : int'(dim);
      if (span > 4096) begin
         span = 4096;
      end
      if ($urandom_range(99) < 85) begin
         return COORD_W'($urandom_range(span - 1));
      end
      return COORD_W'($urandom);
   endfunction

   task automatic log_fault(string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("%s", what);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [COLOUR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_IMAGE_WIDTH:    cfg_width   = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT:   cfg_height  = value[DIM_W-1:0];
         CSR_INSIDE_COLOUR:  cfg_inside  = value;
         CSR_OUTSIDE_COLOUR: cfg_outside = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             colour_src_type src, logic [23:0] rgb);
      pending_colour_type entry;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      entry.x      = x;
      entry.y      = y;
      entry.colour = (src == FROM_TABLE) ? colour_type'(rgb) : predict_colour(x, y);
      colours_due.push_back(entry);
      pixels_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (colours_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : result_side
      pending_colour_type want;
      colour_type         got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (colours_due.size() == 0) begin
            log_fault($sformatf("Unexpected result r=%02h g=%02h b=%02h.",
                                got.red, got.green, got.blue));
         end else begin
            want = colours_due.pop_front();
            colours_checked++;
            if (got.red !== want.colour.red || got.green !== want.colour.green ||
                got.blue !== want.colour.blue) begin
               log_fault($sformatf(
                  "Pixel (%0d,%0d): expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h.",
                  want.x, want.y, want.colour.red, want.colour.green, want.colour.blue,
                  got.red, got.green, got.blue));
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Cycle limit reached with %0d results outstanding.", colours_due.size());
         $display("tb_mandelbrot_pixel_colour: errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [DIM_W-1:0]    w;
      logic [DIM_W-1:0]    h;
      logic [COLOUR_W-1:0] ins;
      logic [COLOUR_W-1:0] outs;
      int unsigned         lo;
      int unsigned         hi;
      int unsigned         mid;

      for (int i = 0; i < MAX_ITERATIONS; i++) begin
         lo = 0;
         hi = 65535;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (fifth_power_fits(mid, i)) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         shape_lut[i] = lo;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         if (DIRECTED[n].kind == ROW_WRITE) begin
            drain_results();
            write_reg(DIRECTED[n].index, DIRECTED[n].wdata);
         end else begin
            send_pixel(DIRECTED[n].x, DIRECTED[n].y, DIRECTED[n].src, DIRECTED[n].rgb);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         ins  = COLOUR_W'($urandom);
         outs = COLOUR_W'($urandom);
         w    = DIM_W'($urandom_range(1, 4096));
         h    = DIM_W'($urandom_range(1, 4096));
         case (ph)
            0: begin
               w    = RESET_IMAGE_WIDTH;
               h    = RESET_IMAGE_HEIGHT;
               ins  = RESET_INSIDE_COLOUR;
               outs = RESET_OUTSIDE_COLOUR;
            end
            1: begin
               w    = 1;
               h    = 1;
               ins  = 24'hFFFFFF;
               outs = 24'h000000;
            end
            2: begin
               w    = 4096;
               h    = 4096;
               ins  = 24'h000000;
               outs = 24'hFFFFFF;
            end
            3: begin
               w = 0;
               h = 0;
            end
            4: begin
               w = 8191;
               h = 8191;
            end
            5: begin
               w = 64;
               h = 48;
            end
            6, 7: begin
               w = DIM_W'($urandom_range(1, 32));
               h = DIM_W'($urandom_range(1, 32));
            end
            default: ;
         endcase

         drain_results();
         write_reg(CSR_IMAGE_WIDTH,    {11'($urandom), w});
         write_reg(CSR_IMAGE_HEIGHT,   {11'($urandom), h});
         write_reg(CSR_INSIDE_COLOUR,  ins);
         write_reg(CSR_OUTSIDE_COLOUR, outs);

         case (idle_mode_type'(ph % 4))
            IDLE_NONE: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct  = BUSY_PCT;
               recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct  = 0;
               recv_stall_pct = BUSY_PCT;
            end
            default: begin
               send_idle_pct  = LIGHT_PCT;
               recv_stall_pct = LIGHT_PCT;
            end
         endcase

         repeat (PIXELS_PER_PH) begin
            send_pixel(pick_coord(cfg_width), pick_coord(cfg_height), FROM_PREDICTOR, 24'h0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (colours_due.size() != 0) begin
         log_fault($sformatf("%0d expected results never arrived.", colours_due.size()));
      end

      $display("Sent %0d pixel requests and checked %0d colours over %0d register settings,",
               pixels_sent, colours_checked, PHASES + 1);
      $display("including zero, minimum and maximum image sizes and four idling patterns.");
      if (fault_count == 0) begin
         $display("tb_mandelbrot_pixel_colour: clean");
      end else begin
         $display("%0d failures in total.", fault_count);
         $display("tb_mandelbrot_pixel_colour: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
